FILE: rtl/lfpd_pkg.sv
// Shared constants, types and codes of the line follower PD motor controller.
`default_nettype none

package lfpd_pkg;

  // Field and register widths
  localparam int SAMPLE_BITS = 10;
  localparam int COUNT_BITS  = 16;
  localparam int THR_W       = 10;
  localparam int GAIN_W      = 12;
  localparam int DUTY_CFG_W  = 16;
  localparam int RUN_CFG_W   = 16;
  localparam int CFG_W       = 16;
  localparam int CFG_IDX_W   = 3;
  localparam int ERR_W       = 4;
  localparam int MODE_W      = 2;
  localparam int DUTY_OUT_W  = 17;
  localparam int FRAC_BITS   = 8;

  // Compare widths
  localparam int CMP_W = (SAMPLE_BITS > THR_W) ? SAMPLE_BITS : THR_W;
  localparam int RUN_W = (COUNT_BITS > RUN_CFG_W) ? COUNT_BITS : RUN_CFG_W;

  // Datapath widths: |diff| <= 10, times 30, times a 12-bit gain fits 21 bits
  localparam int PROD_W     = 21;
  localparam int DIVD_W     = PROD_W + FRAC_BITS;
  localparam int DIVS_W     = COUNT_BITS + 1;
  localparam int DIV_CNT_W  = $clog2(DIVD_W + 1);
  localparam int P_W        = GAIN_W + 3;
  localparam int S_W        = DIVD_W + 2;
  localparam int SUM_W      = S_W + 4;
  localparam int QV_W       = SUM_W - FRAC_BITS;

  // Constants of the control law
  localparam int EDGE_ERR   = 5;
  localparam int MAX_DUTY   = 65535;

  localparam logic signed [ERR_W-1:0] ERR_POS_EDGE = ERR_W'(EDGE_ERR);
  localparam logic signed [ERR_W-1:0] ERR_NEG_EDGE = ERR_W'(-EDGE_ERR);
  localparam logic signed [ERR_W-1:0] ERR_POS_ONE  = ERR_W'(1);
  localparam logic signed [ERR_W-1:0] ERR_NEG_ONE  = ERR_W'(-1);
  localparam logic signed [ERR_W-1:0] ERR_ZERO     = ERR_W'(0);

  localparam logic signed [DUTY_OUT_W-1:0] DUTY_CCW_RIGHT = DUTY_OUT_W'(33000);
  localparam logic signed [DUTY_OUT_W-1:0] DUTY_CW_LEFT   = DUTY_OUT_W'(32000);
  localparam logic signed [DUTY_OUT_W-1:0] DUTY_SPIN_BACK = DUTY_OUT_W'(-20000);
  localparam logic signed [DUTY_OUT_W-1:0] DUTY_MAX       = DUTY_OUT_W'(MAX_DUTY);
  localparam logic signed [DUTY_OUT_W-1:0] DUTY_MIN       = DUTY_OUT_W'(-MAX_DUTY);
  localparam logic signed [DUTY_OUT_W-1:0] DUTY_REV_ONE   = DUTY_OUT_W'(-1);
  localparam logic signed [DUTY_OUT_W-1:0] DUTY_ZERO      = DUTY_OUT_W'(0);

  // Register reset values
  localparam logic [THR_W-1:0]      RST_ON_TAPE  = THR_W'(200);
  localparam logic [THR_W-1:0]      RST_BAR_HI   = THR_W'(37);
  localparam logic [THR_W-1:0]      RST_BAR_LO   = THR_W'(27);
  localparam logic [GAIN_W-1:0]     RST_PROP     = GAIN_W'(970);
  localparam logic [GAIN_W-1:0]     RST_DERIV    = GAIN_W'(306);
  localparam logic [DUTY_CFG_W-1:0] RST_NOMINAL  = DUTY_CFG_W'(30000);
  localparam logic [RUN_CFG_W-1:0]  RST_SPIN     = RUN_CFG_W'(20);
  localparam logic [RUN_CFG_W-1:0]  RST_CLEAR    = RUN_CFG_W'(15);

  // Register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ON_TAPE = 3'd0,
    CFG_BAR_HI  = 3'd1,
    CFG_BAR_LO  = 3'd2,
    CFG_PROP    = 3'd3,
    CFG_DERIV   = 3'd4,
    CFG_NOMINAL = 3'd5,
    CFG_SPIN    = 3'd6,
    CFG_CLEAR   = 3'd7
  } cfg_idx_t;

  // Drive modes
  typedef enum logic [MODE_W-1:0] {
    MODE_PD  = 2'd0,
    MODE_CCW = 2'd1,
    MODE_CW  = 2'd2,
    MODE_BAR = 2'd3
  } drive_mode_t;

  // Sensor classes
  typedef enum logic [1:0] {
    SENSE_OFF  = 2'd0,
    SENSE_TAPE = 2'd1,
    SENSE_BAR  = 2'd2
  } sense_t;

  // Divider request and response
  typedef struct packed {
    logic              start;
    logic [DIVD_W-1:0] dividend;
    logic [DIVS_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [DIVD_W-1:0] quotient;
  } div_rsp_t;

endpackage

`default_nettype wire

FILE: rtl/lfpd_if.sv
// Valid/ready channel interfaces for sensor samples and motor results.
`default_nettype none

interface lfpd_in_if import lfpd_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic [SAMPLE_BITS-1:0] left_sample;
  logic [SAMPLE_BITS-1:0] right_sample;

  modport source (output valid, output left_sample, output right_sample, input ready);
  modport sink   (input valid, input left_sample, input right_sample, output ready);
endinterface

interface lfpd_out_if import lfpd_pkg::*; ();
  logic                          valid;
  logic                          ready;
  logic                          at_bar;
  logic signed [ERR_W-1:0]       track_error;
  logic [MODE_W-1:0]             drive_mode;
  logic signed [DUTY_OUT_W-1:0]  left_duty;
  logic signed [DUTY_OUT_W-1:0]  right_duty;

  modport source (output valid, output at_bar, output track_error, output drive_mode,
                  output left_duty, output right_duty, input ready);
  modport sink   (input valid, input at_bar, input track_error, input drive_mode,
                  input left_duty, input right_duty, output ready);
endinterface

`default_nettype wire

FILE: rtl/lfpd_div.sv
// Restoring unsigned divider, one quotient bit per cycle.
`default_nettype none

module lfpd_div import lfpd_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  div_req_t req,
  output div_rsp_t rsp
);

  logic                 busy_r, busy_nxt;
  logic                 done_r, done_nxt;
  logic [DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic [DIVS_W-1:0]    rem_r, rem_nxt;
  logic [DIVS_W-1:0]    dvs_r, dvs_nxt;
  logic [DIVD_W-1:0]    quo_r, quo_nxt;
  logic [DIVS_W:0]      shifted;
  logic [DIVS_W:0]      trial;
  logic                 fits;

  // Trial subtract of the shifted remainder
  always_comb begin
    shifted = {rem_r, quo_r[DIVD_W-1]};
    trial   = shifted - {1'b0, dvs_r};
    fits    = shifted >= {1'b0, dvs_r};
  end

  // Next state of the iteration
  always_comb begin
    busy_nxt = busy_r;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    quo_nxt  = quo_r;
    done_nxt = busy_r && (cnt_r == DIV_CNT_W'(1));
    if (req.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = DIV_CNT_W'(DIVD_W);
      rem_nxt  = '0;
      dvs_nxt  = req.divisor;
      quo_nxt  = req.dividend;
    end else if (busy_r) begin
      cnt_nxt = cnt_r - DIV_CNT_W'(1);
      if (cnt_r == DIV_CNT_W'(1)) begin
        busy_nxt = 1'b0;
      end
      rem_nxt = fits ? trial[DIVS_W-1:0] : shifted[DIVS_W-1:0];
      quo_nxt = {quo_r[DIVD_W-2:0], fits};
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
    quo_r <= quo_nxt;
  end

  assign rsp.done     = done_r;
  assign rsp.quotient = quo_r;

  // A start always launches an iteration
  a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    req.start |=> busy_r)
    else $error("divider did not go busy after start");

  // Done is reported only once the iteration has stopped
  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> !busy_r)
    else $error("divider done while still busy");

  // The last iteration is followed by done
  a_last_done: assert property (@(posedge clk) disable iff (!rst_n)
    (busy_r && !req.start && cnt_r == DIV_CNT_W'(1)) |=> done_r)
    else $error("divider missed done after last bit");

endmodule

`default_nettype wire

FILE: rtl/line_follow_pd_motor_control.sv
// Two-sensor line follower PD motor controller, top level.
//
// in_ch carries one left and one right reflectance sample per transfer;
// out_ch returns one result per input: bar flag, track error, drive mode and
// signed left and right wheel duties. The cfg_ port writes one control
// register per cycle with cfg_we; it is to be written only while the block
// is idle, and the block itself does not enforce this. An item runs through
// a small sequencer: classify and update the run state, form the slope
// numerator and span, a bit-serial divide of the slope (one quotient bit per
// cycle for 29 bits), then the two duties through one shared adder and
// saturator, and a final load of the output register. in_ch is ready again
// once the result is loaded there, so a new item is taken only after the last
// has left the sequencer. A bar sample skips the arithmetic and goes from
// classification straight to the final load. The output register holds a
// result until out_ch takes it; the next item may be accepted and computed
// meanwhile, and it waits in the final step while the earlier result is
// still pending. Reset (rst_n low at a clock edge) restores the register
// defaults, clears the error and run history, empties the output register.
`default_nettype none

module line_follow_pd_motor_control import lfpd_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  lfpd_in_if.sink              in_ch,
  lfpd_out_if.source           out_ch,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata
);

  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_CLASS  = 7'b0000010,
    S_MUL    = 7'b0000100,
    S_DIV    = 7'b0001000,
    S_DUTY_L = 7'b0010000,
    S_DUTY_R = 7'b0100000,
    S_FIN    = 7'b1000000
  } state_t;

  localparam logic signed [QV_W-1:0] QV_MAX = QV_W'(MAX_DUTY);
  localparam logic signed [QV_W-1:0] QV_MIN = QV_W'(-MAX_DUTY);
  localparam logic [SUM_W-1:0]       RND    = SUM_W'((1 << FRAC_BITS) - 1);

  // Control registers
  logic [THR_W-1:0]      thr_r, bar_hi_r, bar_lo_r;
  logic [GAIN_W-1:0]     pg_r, dg_r;
  logic [DUTY_CFG_W-1:0] nom_r;
  logic [RUN_CFG_W-1:0]  spin_r, clear_r;

  // Sequencer and history
  state_t                  state_r, state_nxt;
  logic signed [ERR_W-1:0] last_err_r, last_err_nxt;
  logic                    last_valid_r, last_valid_nxt;
  logic [COUNT_BITS-1:0]   run_len_r, run_len_nxt;
  logic [COUNT_BITS-1:0]   prior_len_r, prior_len_nxt;
  logic                    prior_valid_r, prior_valid_nxt;
  logic signed [ERR_W-1:0] prior_err_r, prior_err_nxt;

  // Item datapath
  logic [SAMPLE_BITS-1:0]        left_smp_r, left_smp_nxt;
  logic [SAMPLE_BITS-1:0]        right_smp_r, right_smp_nxt;
  logic signed [ERR_W-1:0]       err_r, err_nxt;
  logic                          bar_r, bar_nxt;
  logic signed [P_W:0]           p_r, p_nxt;
  logic                          neg_r, neg_nxt;
  logic signed [S_W-1:0]         s_r, s_nxt;
  logic signed [DUTY_OUT_W-1:0]  left_q_r, left_q_nxt;
  logic signed [DUTY_OUT_W-1:0]  right_q_r, right_q_nxt;

  // Output register
  logic                          out_valid_r, out_valid_nxt;
  logic                          out_bar_r, out_bar_nxt;
  logic signed [ERR_W-1:0]       out_err_r, out_err_nxt;
  drive_mode_t                   out_mode_r, out_mode_nxt;
  logic signed [DUTY_OUT_W-1:0]  out_left_r, out_left_nxt;
  logic signed [DUTY_OUT_W-1:0]  out_right_r, out_right_nxt;

  // Combinational terms
  sense_t                  sense_l, sense_r;
  logic                    cls_bar;
  logic signed [ERR_W-1:0] err_c, prev_err;
  logic signed [ERR_W:0]   diff_c;
  logic [ERR_W:0]          absd_c;
  logic [8:0]              m30_c;
  logic [PROD_W-1:0]       prod_c;
  logic [DIVS_W-1:0]       span_c;
  logic                    d_zero;
  logic [P_W-1:0]          p_mag;
  logic [RUN_W-1:0]        run_ext;
  logic signed [S_W-1:0]   p_sh, d_mag;
  logic signed [SUM_W-1:0] s_ext, s5, s8, term, nq, sum_c, rnd_c;
  logic                    s_pos;
  logic signed [QV_W-1:0]  qv;
  logic signed [DUTY_OUT_W-1:0] duty_c;
  logic                    out_free;
  logic                    in_xfer;
  div_req_t                div_req;
  div_rsp_t                div_rsp;

  function automatic sense_t classify(input logic [SAMPLE_BITS-1:0] smp,
                                      input logic [THR_W-1:0] thr,
                                      input logic [THR_W-1:0] hi,
                                      input logic [THR_W-1:0] lo);
    logic [CMP_W-1:0] v;
    v = CMP_W'(smp);
    if (v > CMP_W'(thr)) begin
      return SENSE_TAPE;
    end
    if (v < CMP_W'(hi) && v > CMP_W'(lo)) begin
      return SENSE_BAR;
    end
    return SENSE_OFF;
  endfunction

  lfpd_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  assign in_ch.ready = (state_r == S_IDLE);
  assign in_xfer     = in_ch.valid && in_ch.ready;
  assign out_free    = !out_valid_r || out_ch.ready;
  assign run_ext     = RUN_W'(run_len_r);

  // Classify both samples and form the error
  always_comb begin
    sense_l  = classify(left_smp_r, thr_r, bar_hi_r, bar_lo_r);
    sense_r  = classify(right_smp_r, thr_r, bar_hi_r, bar_lo_r);
    cls_bar  = (sense_l == SENSE_BAR) && (sense_r == SENSE_BAR);
    prev_err = last_valid_r ? last_err_r : ERR_ZERO;
    if (sense_l == SENSE_TAPE && sense_r == SENSE_TAPE) begin
      err_c = ERR_ZERO;
    end else if (sense_l == SENSE_OFF && sense_r == SENSE_TAPE) begin
      err_c = ERR_NEG_ONE;
    end else if (sense_l == SENSE_TAPE && sense_r == SENSE_OFF) begin
      err_c = ERR_POS_ONE;
    end else if (prev_err == ERR_POS_ONE || prev_err == ERR_POS_EDGE) begin
      err_c = ERR_POS_EDGE;
    end else begin
      err_c = ERR_NEG_EDGE;
    end
  end

  // Slope numerator, span and proportional term
  always_comb begin
    diff_c = {err_r[ERR_W-1], err_r} - {prior_err_r[ERR_W-1], prior_err_r};
    absd_c = diff_c[ERR_W] ? $unsigned(-diff_c) : $unsigned(diff_c);
    m30_c  = {absd_c[3:0], 5'b0} - {4'b0, absd_c[3:0], 1'b0};
    prod_c = PROD_W'(m30_c) * PROD_W'(dg_r);
    span_c = {1'b0, prior_len_r} + {1'b0, run_len_r} - DIVS_W'(1);
    if (span_c == '0) begin
      span_c = DIVS_W'(1);
    end
    d_zero = !prior_valid_r ||
             (run_ext > RUN_W'(clear_r) && err_r == ERR_ZERO);
    if (err_r == ERR_POS_EDGE || err_r == ERR_NEG_EDGE) begin
      p_mag = (P_W'(pg_r) << 2) + P_W'(pg_r);
    end else if (err_r == ERR_POS_ONE || err_r == ERR_NEG_ONE) begin
      p_mag = P_W'(pg_r);
    end else begin
      p_mag = '0;
    end
  end

  // Launch the divider from the multiply step
  always_comb begin
    div_req.start    = (state_r == S_MUL);
    div_req.dividend = d_zero ? '0 : {prod_c, {FRAC_BITS{1'b0}}};
    div_req.divisor  = span_c;
  end

  // Combine the proportional and slope terms
  always_comb begin
    p_sh  = {{(S_W-P_W-1-FRAC_BITS){p_r[P_W]}}, p_r, {FRAC_BITS{1'b0}}};
    d_mag = {{(S_W-DIVD_W){1'b0}}, div_rsp.quotient};
  end

  // Shared duty adder, round toward zero, saturate and turn a zero duty into reverse 1
  always_comb begin
    s_ext = {{(SUM_W-S_W){s_r[S_W-1]}}, s_r};
    s5    = (s_ext <<< 2) + s_ext;
    s8    = s_ext <<< 3;
    s_pos = !s_r[S_W-1] && (s_r != '0);
    if (state_r == S_DUTY_L) begin
      term = s_pos ? -s8 : -s5;
    end else begin
      term = s_pos ? s5 : s8;
    end
    nq    = {{(SUM_W-DUTY_CFG_W-FRAC_BITS){1'b0}}, nom_r, {FRAC_BITS{1'b0}}};
    sum_c = nq + term;
    rnd_c = sum_c + (sum_c[SUM_W-1] ? RND : '0);
    qv    = rnd_c[SUM_W-1:FRAC_BITS];
    if (qv > QV_MAX) begin
      duty_c = DUTY_MAX;
    end else if (qv < QV_MIN) begin
      duty_c = DUTY_MIN;
    end else if (qv == '0) begin
      duty_c = DUTY_REV_ONE;
    end else begin
      duty_c = qv[DUTY_OUT_W-1:0];
    end
  end

  // Sequencer
  always_comb begin
    state_nxt       = state_r;
    last_err_nxt    = last_err_r;
    last_valid_nxt  = last_valid_r;
    run_len_nxt     = run_len_r;
    prior_len_nxt   = prior_len_r;
    prior_valid_nxt = prior_valid_r;
    prior_err_nxt   = prior_err_r;
    left_smp_nxt    = left_smp_r;
    right_smp_nxt   = right_smp_r;
    err_nxt         = err_r;
    bar_nxt         = bar_r;
    p_nxt           = p_r;
    neg_nxt         = neg_r;
    s_nxt           = s_r;
    left_q_nxt      = left_q_r;
    right_q_nxt     = right_q_r;
    out_valid_nxt   = out_valid_r && !out_ch.ready;
    out_bar_nxt     = out_bar_r;
    out_err_nxt     = out_err_r;
    out_mode_nxt    = out_mode_r;
    out_left_nxt    = out_left_r;
    out_right_nxt   = out_right_r;

    case (state_r)
      S_IDLE: begin
        if (in_xfer) begin
          left_smp_nxt  = in_ch.left_sample;
          right_smp_nxt = in_ch.right_sample;
          state_nxt     = S_CLASS;
        end
      end

      S_CLASS: begin
        bar_nxt = cls_bar;
        if (cls_bar) begin
          state_nxt = S_FIN;
        end else begin
          // Extend the current run or close it and start a new one
          if (last_valid_r) begin
            if (last_err_r == err_c) begin
              if (run_len_r != '1) begin
                run_len_nxt = run_len_r + COUNT_BITS'(1);
              end
            end else begin
              prior_len_nxt   = run_len_r;
              prior_err_nxt   = last_err_r;
              prior_valid_nxt = 1'b1;
              run_len_nxt     = COUNT_BITS'(1);
            end
          end
          last_err_nxt   = err_c;
          last_valid_nxt = 1'b1;
          err_nxt        = err_c;
          state_nxt      = S_MUL;
        end
      end

      S_MUL: begin
        p_nxt     = err_r[ERR_W-1] ? -$signed({1'b0, p_mag}) : $signed({1'b0, p_mag});
        neg_nxt   = diff_c[ERR_W];
        state_nxt = S_DIV;
      end

      S_DIV: begin
        if (div_rsp.done) begin
          s_nxt     = p_sh + (neg_r ? -d_mag : d_mag);
          state_nxt = S_DUTY_L;
        end
      end

      S_DUTY_L: begin
        left_q_nxt = duty_c;
        state_nxt  = S_DUTY_R;
      end

      S_DUTY_R: begin
        right_q_nxt = duty_c;
        state_nxt   = S_FIN;
      end

      S_FIN: begin
        // Hold here until the output register is free
        if (out_free) begin
          out_valid_nxt = 1'b1;
          if (bar_r) begin
            out_bar_nxt   = 1'b1;
            out_err_nxt   = ERR_ZERO;
            out_mode_nxt  = MODE_BAR;
            out_left_nxt  = DUTY_ZERO;
            out_right_nxt = DUTY_ZERO;
          end else begin
            out_bar_nxt = 1'b0;
            out_err_nxt = err_r;
            if (err_r == ERR_POS_EDGE && run_ext >= RUN_W'(spin_r)) begin
              out_mode_nxt  = MODE_CCW;
              out_left_nxt  = DUTY_SPIN_BACK;
              out_right_nxt = DUTY_CCW_RIGHT;
            end else if (err_r == ERR_NEG_EDGE && run_ext >= RUN_W'(spin_r)) begin
              out_mode_nxt  = MODE_CW;
              out_left_nxt  = DUTY_CW_LEFT;
              out_right_nxt = DUTY_SPIN_BACK;
            end else begin
              out_mode_nxt  = MODE_PD;
              out_left_nxt  = left_q_r;
              out_right_nxt = right_q_r;
            end
          end
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r    <= RST_ON_TAPE;
      bar_hi_r <= RST_BAR_HI;
      bar_lo_r <= RST_BAR_LO;
      pg_r     <= RST_PROP;
      dg_r     <= RST_DERIV;
      nom_r    <= RST_NOMINAL;
      spin_r   <= RST_SPIN;
      clear_r  <= RST_CLEAR;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_ON_TAPE: thr_r    <= cfg_wdata[THR_W-1:0];
        CFG_BAR_HI:  bar_hi_r <= cfg_wdata[THR_W-1:0];
        CFG_BAR_LO:  bar_lo_r <= cfg_wdata[THR_W-1:0];
        CFG_PROP:    pg_r     <= cfg_wdata[GAIN_W-1:0];
        CFG_DERIV:   dg_r     <= cfg_wdata[GAIN_W-1:0];
        CFG_NOMINAL: nom_r    <= cfg_wdata[DUTY_CFG_W-1:0];
        CFG_SPIN:    spin_r   <= cfg_wdata[RUN_CFG_W-1:0];
        CFG_CLEAR:   clear_r  <= cfg_wdata[RUN_CFG_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      last_err_r    <= ERR_ZERO;
      last_valid_r  <= 1'b0;
      run_len_r     <= COUNT_BITS'(1);
      prior_len_r   <= '0;
      prior_valid_r <= 1'b0;
      prior_err_r   <= ERR_ZERO;
      out_valid_r   <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      last_err_r    <= last_err_nxt;
      last_valid_r  <= last_valid_nxt;
      run_len_r     <= run_len_nxt;
      prior_len_r   <= prior_len_nxt;
      prior_valid_r <= prior_valid_nxt;
      prior_err_r   <= prior_err_nxt;
      out_valid_r   <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    left_smp_r  <= left_smp_nxt;
    right_smp_r <= right_smp_nxt;
    err_r       <= err_nxt;
    bar_r       <= bar_nxt;
    p_r         <= p_nxt;
    neg_r       <= neg_nxt;
    s_r         <= s_nxt;
    left_q_r    <= left_q_nxt;
    right_q_r   <= right_q_nxt;
    out_bar_r   <= out_bar_nxt;
    out_err_r   <= out_err_nxt;
    out_mode_r  <= out_mode_nxt;
    out_left_r  <= out_left_nxt;
    out_right_r <= out_right_nxt;
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.at_bar      = out_bar_r;
  assign out_ch.track_error = out_err_r;
  assign out_ch.drive_mode  = out_mode_r;
  assign out_ch.left_duty   = out_left_r;
  assign out_ch.right_duty  = out_right_r;

  // An input transfer always starts classification
  a_xfer_class: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer |=> state_r == S_CLASS)
    else $error("input transfer did not start classification");

  // A bar sample leaves the error and run history untouched
  a_bar_keeps: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CLASS && cls_bar) |=>
      ($stable(run_len_r) && $stable(last_err_r) && $stable(prior_len_r)))
    else $error("bar sample changed run history");

  // Run length never drops to zero
  a_run_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    run_len_r != '0)
    else $error("run length reached zero");

  // A bar hold result carries zero duties and the bar flag
  a_bar_result: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_mode_r == MODE_BAR) |->
      (out_bar_r && out_left_r == DUTY_ZERO && out_right_r == DUTY_ZERO))
    else $error("bar hold result with nonzero duty");

  // The divider finishes only while the sequencer waits for it
  a_div_owner: assert property (@(posedge clk) disable iff (!rst_n)
    div_rsp.done |-> state_r == S_DIV)
    else $error("divider finished outside the divide step");

endmodule

`default_nettype wire

FILE: tb/line_follow_pd_motor_control_tb.sv
// Self-checking testbench for the two-sensor line follower PD motor controller.
module line_follow_pd_motor_control_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import lfpd_pkg::*;

  localparam int LIMIT_CYCLES = 300000;
  localparam int IDLE_PCT     = 37;
  localparam int MAX_REPORTS  = 10;
  localparam int END_WAIT     = 60;
  localparam int PHASE_ITEMS  = 70;
  localparam int SLOPE_GAIN   = 30;
  localparam int SAMPLE_MAX   = 2**SAMPLE_BITS - 1;
  localparam int RUN_MAX      = 2**COUNT_BITS - 1;

  typedef struct packed {
    logic [SAMPLE_BITS-1:0] left_sample;
    logic [SAMPLE_BITS-1:0] right_sample;
  } sensor_pair_t;

  typedef struct packed {
    logic                         at_bar;
    logic signed [ERR_W-1:0]      track_error;
    drive_mode_t                  mode;
    logic signed [DUTY_OUT_W-1:0] left_duty;
    logic signed [DUTY_OUT_W-1:0] right_duty;
  } motor_cmd_t;

  logic                 clk;
  logic                 rst_n;
  logic                 cfg_we;
  cfg_idx_t             cfg_index;
  logic [CFG_W-1:0]     cfg_wdata;

  lfpd_in_if  in_ch();
  lfpd_out_if out_ch();

  line_follow_pd_motor_control u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // Register shadow
  logic [THR_W-1:0]      thr_r, bar_hi_r, bar_lo_r;
  logic [GAIN_W-1:0]     prop_r, deriv_r;
  logic [DUTY_CFG_W-1:0] nominal_r;
  logic [RUN_CFG_W-1:0]  spin_r, clear_r;

  // Error and run history shadow
  int last_err;
  bit last_valid;
  int run_len;
  int prior_len;
  bit prior_valid;
  int prior_err;

  sensor_pair_t pairs_q[$];
  motor_cmd_t   cmds_q[$];
  bit           in_taken;
  bit           quiet;
  int           fail_cnt;
  int           result_cnt;
  int           cycle_cnt;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic sense_t sense_class(logic [SAMPLE_BITS-1:0] s);
    if (s > thr_r) return SENSE_TAPE;
    if (s < bar_hi_r && s > bar_lo_r) return SENSE_BAR;
    return SENSE_OFF;
  endfunction

  // Truncate Q8 toward zero, saturate, and turn a zero duty into reverse 1
  function automatic logic signed [DUTY_OUT_W-1:0] duty_from_q8(longint q8);
    longint v;
    v = q8 / 256;
    if (v > MAX_DUTY) v = MAX_DUTY;
    if (v < -MAX_DUTY) v = -MAX_DUTY;
    if (v == 0) v = -1;
    return DUTY_OUT_W'(v);
  endfunction

  // Work out the wheel command for one sample pair and advance the history
  function automatic motor_cmd_t steer_predict(logic [SAMPLE_BITS-1:0] ls,
                                               logic [SAMPLE_BITS-1:0] rs);
    sense_t     lc, rc;
    int         e, pe;
    longint     d, s, g, nq, span;
    motor_cmd_t r;
    lc = sense_class(ls);
    rc = sense_class(rs);
    r.at_bar = 1'b0;
    r.mode   = MODE_PD;
    if (lc == SENSE_BAR && rc == SENSE_BAR) begin
      r.at_bar      = 1'b1;
      r.track_error = ERR_ZERO;
      r.mode        = MODE_BAR;
      r.left_duty   = DUTY_ZERO;
      r.right_duty  = DUTY_ZERO;
      return r;
    end
    if (lc == SENSE_TAPE && rc == SENSE_TAPE) e = 0;
    else if (lc == SENSE_OFF && rc == SENSE_TAPE) e = -1;
    else if (lc == SENSE_TAPE && rc == SENSE_OFF) e = 1;
    else begin
      // lost the line: steer back toward the side it was last seen on
      pe = last_valid ? last_err : 0;
      e = (pe == 1 || pe == EDGE_ERR) ? EDGE_ERR : -EDGE_ERR;
    end
    // Extend or close the current run of equal errors
    if (last_valid) begin
      if (last_err == e) begin
        if (run_len < RUN_MAX) run_len++;
      end else begin
        prior_len   = run_len;
        prior_err   = last_err;
        prior_valid = 1'b1;
        run_len     = 1;
      end
    end
    d = 0;
    if (prior_valid) begin
      span = longint'(prior_len) + longint'(run_len) - 1;
      if (span <= 0) span = 1;
      d = longint'(e - prior_err) * SLOPE_GAIN * longint'(deriv_r) * 256 / span;
    end
    if (run_len > int'(clear_r) && e == 0) d = 0;
    last_err   = e;
    last_valid = 1'b1;
    s  = longint'(e) * longint'(prop_r) * 256 + d;
    g  = 5 * s;
    nq = longint'(nominal_r) * 256;
    r.track_error = ERR_W'(e);
    if (e == EDGE_ERR && run_len >= int'(spin_r)) begin
      r.mode       = MODE_CCW;
      r.right_duty = DUTY_CCW_RIGHT;
      r.left_duty  = DUTY_SPIN_BACK;
    end else if (e == -EDGE_ERR && run_len >= int'(spin_r)) begin
      r.mode       = MODE_CW;
      r.right_duty = DUTY_SPIN_BACK;
      r.left_duty  = DUTY_CW_LEFT;
    end else if (g > 0) begin
      r.right_duty = duty_from_q8(nq + g);
      r.left_duty  = duty_from_q8(nq - 8 * s);
    end else if (g < 0) begin
      r.left_duty  = duty_from_q8(nq - g);
      r.right_duty = duty_from_q8(nq + 8 * s);
    end else begin
      r.left_duty  = duty_from_q8(nq);
      r.right_duty = duty_from_q8(nq);
    end
    return r;
  endfunction

  // Try to pick a sample that lands in the requested class under the current thresholds
  function automatic logic [SAMPLE_BITS-1:0] sample_of(sense_t c);
    int v, thr, hi, lo, k;
    thr = int'(thr_r);
    hi  = int'(bar_hi_r);
    lo  = int'(bar_lo_r);
    case (c)
      SENSE_TAPE: begin
        v = (thr < SAMPLE_MAX) ? $urandom_range(SAMPLE_MAX, thr + 1) : $urandom_range(SAMPLE_MAX);
      end
      SENSE_BAR: begin
        v = (hi > lo + 1) ? $urandom_range(hi - 1, lo + 1) : $urandom_range(SAMPLE_MAX);
      end
      default: begin
        v = $urandom_range(thr);
        for (k = 0; k < 4; k++)
          if (v < hi && v > lo) v = $urandom_range(thr);
      end
    endcase
    return SAMPLE_BITS'(v);
  endfunction

  task automatic add_pair(int l, int r);
    pairs_q.push_back('{left_sample: SAMPLE_BITS'(l), right_sample: SAMPLE_BITS'(r)});
  endtask

  // Mostly runs of one sensor pattern, so run lengths can reach the spin and clear limits
  task automatic random_phase(int n);
    int     pushed, k, len, i;
    bit     noise, mixed;
    sense_t lc, rc;
    pushed = 0;
    while (pushed < n) begin
      k     = $urandom_range(99);
      noise = 1'b0;
      mixed = 1'b0;
      lc    = SENSE_OFF;
      rc    = SENSE_OFF;
      len   = ($urandom_range(99) < 70) ? $urandom_range(1, 8) : $urandom_range(10, 45);
      if (k < 25) begin
        lc = SENSE_TAPE; rc = SENSE_TAPE;
      end else if (k < 40) begin
        rc = SENSE_TAPE;
      end else if (k < 55) begin
        lc = SENSE_TAPE;
      end else if (k < 78) begin
        lc = SENSE_OFF;
      end else if (k < 85) begin
        lc = SENSE_BAR; rc = SENSE_BAR; len = $urandom_range(1, 3);
      end else if (k < 92) begin
        mixed = 1'b1;
      end else begin
        noise = 1'b1; len = $urandom_range(1, 3);
      end
      for (i = 0; i < len; i++) begin
        if (noise)
          add_pair($urandom_range(SAMPLE_MAX), $urandom_range(SAMPLE_MAX));
        else if (mixed)
          add_pair(sample_of(sense_t'($urandom_range(2))), sample_of(sense_t'($urandom_range(2))));
        else
          add_pair(sample_of(lc), sample_of(rc));
      end
      pushed += len;
    end
  endtask

  task automatic cfg_write(cfg_idx_t idx, int unsigned val);
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_wdata = CFG_W'(val);
    case (idx)
      CFG_ON_TAPE: thr_r     = THR_W'(val);
      CFG_BAR_HI:  bar_hi_r  = THR_W'(val);
      CFG_BAR_LO:  bar_lo_r  = THR_W'(val);
      CFG_PROP:    prop_r    = GAIN_W'(val);
      CFG_DERIV:   deriv_r   = GAIN_W'(val);
      CFG_NOMINAL: nominal_r = DUTY_CFG_W'(val);
      CFG_SPIN:    spin_r    = RUN_CFG_W'(val);
      CFG_CLEAR:   clear_r   = RUN_CFG_W'(val);
      default: ;
    endcase
  endtask

  task automatic load_regs(int unsigned thr, int unsigned hi, int unsigned lo,
                           int unsigned pg, int unsigned dg, int unsigned nom,
                           int unsigned spin, int unsigned clr);
    cfg_write(CFG_ON_TAPE, thr);
    cfg_write(CFG_BAR_HI, hi);
    cfg_write(CFG_BAR_LO, lo);
    cfg_write(CFG_PROP, pg);
    cfg_write(CFG_DERIV, dg);
    cfg_write(CFG_NOMINAL, nom);
    cfg_write(CFG_SPIN, spin);
    cfg_write(CFG_CLEAR, clr);
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic load_random_regs();
    int unsigned lo;
    lo = $urandom_range(150);
    load_regs($urandom_range(40, 1000), lo + $urandom_range(80), lo,
              $urandom_range(4095), $urandom_range(4095), $urandom_range(65535),
              $urandom_range(1, 40), $urandom_range(1, 40));
  endtask

  // Hold until every queued pair has transferred and every result has come back
  task automatic drain();
    while (pairs_q.size() != 0 || cmds_q.size() != 0) @(negedge clk);
  endtask

  // Sample pair driver
  always @(negedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else if (!in_ch.valid || in_taken) begin
      if (pairs_q.size() != 0 && (quiet || $urandom_range(99) >= IDLE_PCT)) begin
        in_ch.valid        <= 1'b1;
        in_ch.left_sample  <= pairs_q[0].left_sample;
        in_ch.right_sample <= pairs_q[0].right_sample;
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // Result backpressure
  always @(negedge clk) begin
    out_ch.ready <= rst_n && (quiet || $urandom_range(99) >= IDLE_PCT);
  end

  // Predict on each input transfer, check each result transfer
  always @(posedge clk) begin
    motor_cmd_t want;
    cycle_cnt++;
    if (cycle_cnt > LIMIT_CYCLES) begin
      $display("timeout after %0d cycles", cycle_cnt);
      $display("*** FAILED ***");
      $finish;
    end
    in_taken <= rst_n && in_ch.valid && in_ch.ready;
    if (rst_n && in_ch.valid && in_ch.ready) begin
      cmds_q.push_back(steer_predict(in_ch.left_sample, in_ch.right_sample));
      void'(pairs_q.pop_front());
    end
    if (rst_n && out_ch.valid && out_ch.ready) begin
      result_cnt++;
      if (cmds_q.size() == 0) begin
        fail_cnt++;
        if (fail_cnt <= MAX_REPORTS)
          $display("result %0d arrived with nothing outstanding", result_cnt);
      end else begin
        want = cmds_q.pop_front();
        if (want.at_bar !== out_ch.at_bar || want.track_error !== out_ch.track_error ||
            want.mode !== out_ch.drive_mode || want.left_duty !== out_ch.left_duty ||
            want.right_duty !== out_ch.right_duty) begin
          fail_cnt++;
          if (fail_cnt <= MAX_REPORTS)
            $display({"result %0d mismatch: expected bar %0d err %0d mode %0d L %0d R %0d,",
                      " got bar %0d err %0d mode %0d L %0d R %0d"}, result_cnt,
                     want.at_bar, want.track_error, want.mode, want.left_duty,
                     want.right_duty, out_ch.at_bar, out_ch.track_error,
                     out_ch.drive_mode, out_ch.left_duty, out_ch.right_duty);
        end
      end
    end
  end

  // Stimulus sequence
  initial begin
    rst_n              = 1'b0;
    cfg_we             = 1'b0;
    cfg_index          = CFG_ON_TAPE;
    cfg_wdata          = '0;
    in_ch.valid        = 1'b0;
    in_ch.left_sample  = '0;
    in_ch.right_sample = '0;
    out_ch.ready       = 1'b0;
    in_taken           = 1'b0;
    quiet              = 1'b0;
    fail_cnt           = 0;
    result_cnt         = 0;
    cycle_cnt          = 0;
    thr_r     = RST_ON_TAPE;
    bar_hi_r  = RST_BAR_HI;
    bar_lo_r  = RST_BAR_LO;
    prop_r    = RST_PROP;
    deriv_r   = RST_DERIV;
    nominal_r = RST_NOMINAL;
    spin_r    = RST_SPIN;
    clear_r   = RST_CLEAR;
    last_err    = 0;
    last_valid  = 1'b0;
    run_len     = 1;
    prior_len   = 0;
    prior_valid = 1'b0;
    prior_err   = 0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed: lost line right after reset, every sensor pattern, band edges
    add_pair(0, 0);
    add_pair(1023, 1023);
    add_pair(0, 1023);
    add_pair(1023, 0);
    add_pair(30, 30);
    add_pair(28, 36);
    add_pair(27, 37);
    add_pair(201, 200);
    add_pair(200, 201);
    add_pair(30, 1023);
    add_pair(1023, 30);
    add_pair(30, 0);
    add_pair(0, 30);
    add_pair(0, 0);
    add_pair(0, 0);
    add_pair(0, 0);
    add_pair(341, 682);
    add_pair(682, 341);
    add_pair(512, 512);
    add_pair(1023, 1023);
    add_pair(0, 0);
    drain();

    // Random phases over several register settings, extremes among them
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        1: load_regs(0, 1023, 0, 4095, 4095, 65535, 1, 1);
        2: load_regs(1023, 0, 1023, 0, 0, 0, 65535, 65535);
        3: begin
          quiet = 1'b1;
          load_random_regs();
        end
        5: load_regs(RST_ON_TAPE, RST_BAR_HI, RST_BAR_LO, RST_PROP, RST_DERIV,
                     RST_NOMINAL, RST_SPIN, RST_CLEAR);
        default: load_random_regs();
      endcase
      random_phase(PHASE_ITEMS);
      drain();
      quiet = 1'b0;
    end

    repeat (END_WAIT) @(negedge clk);
    if (fail_cnt == 0 && cmds_q.size() == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

endmodule

FILE: filelist.f
rtl/lfpd_pkg.sv
rtl/lfpd_if.sv
rtl/lfpd_div.sv
rtl/line_follow_pd_motor_control.sv
tb/line_follow_pd_motor_control_tb.sv
